[hdl/srt_pkg.sv]
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants for signed_integer_to_radix_text
// Register map, character codes, back-end states and alphabet helpers.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int DEF_MAX_RADIX  = 16;
  localparam int DEF_VALUE_BITS = 32;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int BASE_W      = 5;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int ALPHA_SLOTS = 16;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  localparam logic [BASE_W-1:0]     BASE_RESET   = 5'd10;
  localparam logic [CFG_DATA_W-1:0] DIGITS_LO_RESET = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] DIGITS_HI_RESET = 64'h4645_4443_4241_3938;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_LENGTH = 2'd0,
    REG_DIGITS_LOW  = 2'd1,
    REG_DIGITS_HIGH = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [BASE_W-1:0]     base_length;
    logic [CFG_DATA_W-1:0] digits_low;
    logic [CFG_DATA_W-1:0] digits_high;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    base_length: BASE_RESET,
    digits_low:  DIGITS_LO_RESET,
    digits_high: DIGITS_HI_RESET
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_OUT
  } back_state_e;

  function automatic logic [CHAR_W-1:0] digit_char(cfg_t c, logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d[DIGIT_W-1]) begin
      ch = c.digits_high[{d[DIGIT_W-2:0], 3'b000} +: CHAR_W];
    end else begin
      ch = c.digits_low[{d[DIGIT_W-2:0], 3'b000} +: CHAR_W];
    end
    return ch;
  endfunction

  // radix in range, no NUL/sign characters, no repeated digit among used slots
  function automatic logic alphabet_ok(cfg_t c, int unsigned cap);
    logic              ok;
    logic [CHAR_W-1:0] ci;
    ok = 1'b1;
    if (c.base_length < BASE_W'(2) || 32'(c.base_length) > cap ||
        32'(c.base_length) > ALPHA_SLOTS) begin
      ok = 1'b0;
    end
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      ci = digit_char(c, DIGIT_W'(i));
      if (BASE_W'(i) < c.base_length) begin
        if (ci == CHAR_NUL || ci == CHAR_PLUS || ci == CHAR_MINUS) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
          if (BASE_W'(j) < c.base_length && ci == digit_char(c, DIGIT_W'(j))) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

endpackage

[hdl/srt_value_if.sv]
// ----------------------------------------------------------------------------
// srt_value_if: input stream of signed values
// Valid/ready channel carrying one two's complement number per word.
// ----------------------------------------------------------------------------
interface srt_value_if #(
  parameter int VALUE_BITS = srt_pkg::DEF_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[hdl/srt_char_if.sv]
// ----------------------------------------------------------------------------
// srt_char_if: output stream of characters
// Valid/ready channel carrying one character and an end-of-number flag per word.
// ----------------------------------------------------------------------------
interface srt_char_if;
  logic                        valid;
  logic                        ready;
  logic [srt_pkg::CHAR_W-1:0]  character;
  logic                        last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

[hdl/signed_integer_to_radix_text.sv]
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text: signed integer to text in a programmable radix
// Each input word is a signed number; the block returns its text one
// character per output word, a leading '-' for negatives, most significant
// digit first, with last set on the final digit. Radix and the 16-character
// digit alphabet are set through the write port (index 0 base_length, 1
// digits 0-7, 2 digits 8-15); an unusable setting (radix below 2 or above
// MAX_RADIX or 16, a NUL, '+' or '-' digit, or a repeated digit among the
// used digits) makes the block drop input words without output. Each digit
// comes from the bit-serial divider and is then read back out of the digit
// stack. A two-word queue lets up to two further inputs be taken during a
// conversion.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text #(
  parameter int MAX_RADIX  = srt_pkg::DEF_MAX_RADIX,
  parameter int VALUE_BITS = srt_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [srt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  srt_value_if.sink                       in_i,
  srt_char_if.source                      out_o
);
  import srt_pkg::*;

  cfg_t                cfg;
  logic                push, full, pop, empty;
  logic [VALUE_BITS:0] push_data, pop_data;

  srt_front #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cfg_o       (cfg),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  srt_queue #(
    .DATA_W (VALUE_BITS + 1)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  srt_back #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

[hdl/srt_front.sv]
// ----------------------------------------------------------------------------
// srt_front: configuration registers and input classification
// Holds the radix and alphabet, keeps a registered alphabet check, drops words
// that cannot be rendered and queues sign plus magnitude of the others.
// ----------------------------------------------------------------------------
module srt_front #(
  parameter int MAX_RADIX  = srt_pkg::DEF_MAX_RADIX,
  parameter int VALUE_BITS = srt_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [srt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  srt_value_if.sink                       in_i,
  output srt_pkg::cfg_t                   cfg_o,
  output logic                            push_o,
  output logic [VALUE_BITS:0]             push_data_o,
  input  logic                            full_i
);
  import srt_pkg::*;

  localparam int RADIX_CAP = (MAX_RADIX < ALPHA_SLOTS) ? MAX_RADIX : ALPHA_SLOTS;

  cfg_t                  cfg_q, cfg_d;
  logic                  ok_q;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BASE_LENGTH: cfg_d.base_length = cfg_data_i[BASE_W-1:0];
        REG_DIGITS_LOW:  cfg_d.digits_low  = cfg_data_i;
        REG_DIGITS_HIGH: cfg_d.digits_high = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
      ok_q  <= alphabet_ok(CFG_RESET, RADIX_CAP);
    end else begin
      cfg_q <= cfg_d;
      ok_q  <= alphabet_ok(cfg_d, RADIX_CAP);
    end
  end

  // most negative value wraps to 2^(VALUE_BITS-1) as unsigned
  assign neg = in_i.value[VALUE_BITS-1];
  assign mag = neg ? (~in_i.value + VALUE_BITS'(1)) : in_i.value;

  assign in_i.ready  = !full_i;
  assign push_o      = in_i.valid && !full_i && ok_q;
  assign push_data_o = {neg, mag};
  assign cfg_o       = cfg_q;

endmodule

[hdl/srt_queue.sv]
// ----------------------------------------------------------------------------
// srt_queue: small FIFO between front and back
// Two-entry register queue of sign plus magnitude words.
// ----------------------------------------------------------------------------
module srt_queue #(
  parameter int DATA_W = srt_pkg::DEF_VALUE_BITS + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              empty_o
);
  import srt_pkg::*;

  logic [DATA_W-1:0] entry_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              do_push, do_pop;

  assign full_o     = count_q == 2'd2;
  assign empty_o    = count_q == 2'd0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[hdl/srt_back.sv]
// ----------------------------------------------------------------------------
// srt_back: digit extraction and character output
// Bit-serial restoring division by the radix fills a digit stack, least
// significant digit first; the stack is then drained through the output
// register, most significant digit first, after an optional minus sign.
// ----------------------------------------------------------------------------
module srt_back #(
  parameter int MAX_RADIX  = srt_pkg::DEF_MAX_RADIX,
  parameter int VALUE_BITS = srt_pkg::DEF_VALUE_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srt_pkg::cfg_t       cfg_i,
  input  logic                empty_i,
  input  logic [VALUE_BITS:0] pop_data_i,
  output logic                pop_o,
  srt_char_if.source          out_o
);
  import srt_pkg::*;

  localparam int RADIX_CAP = (MAX_RADIX < ALPHA_SLOTS) ? MAX_RADIX : ALPHA_SLOTS;
  localparam int REM_W     = (RADIX_CAP > 2) ? $clog2(RADIX_CAP) : 1;
  localparam int AW        = $clog2(VALUE_BITS);
  localparam int CNT_W     = $clog2(VALUE_BITS + 1);

  back_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] quot_q, quot_next;
  logic [REM_W-1:0]      rem_q, rem_next;
  logic [AW-1:0]         bit_q;
  logic [CNT_W-1:0]      cnt_q, cnt_m1;
  logic                  neg_q;
  logic [DIGIT_W-1:0]    stack_q [VALUE_BITS];
  logic [DIGIT_W-1:0]    rd_q;

  logic                  valid_q, last_q;
  logic [CHAR_W-1:0]     char_q;

  logic [REM_W:0]        trial, radix_r, trial_sub;
  logic                  ge, div_done, quot_zero, slot_free;
  logic                  load, step, push_dig, emit_sign, rd_en, emit_dig;

  // one quotient bit per cycle
  assign radix_r   = (REM_W + 1)'(cfg_i.base_length);
  assign trial     = {rem_q, quot_q[VALUE_BITS-1]};
  assign ge        = trial >= radix_r;
  assign trial_sub = trial - radix_r;
  assign rem_next  = ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
  assign quot_next = {quot_q[VALUE_BITS-2:0], ge};
  assign div_done  = bit_q == '0;
  assign quot_zero = quot_next == '0;
  assign cnt_m1    = cnt_q - CNT_W'(1);
  assign slot_free = !valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!empty_i) state_d = ST_DIV;
      ST_DIV: begin
        if (div_done && quot_zero) state_d = neg_q ? ST_SIGN : ST_READ;
      end
      ST_SIGN: if (slot_free) state_d = ST_READ;
      ST_READ: state_d = ST_OUT;
      ST_OUT: begin
        if (slot_free) state_d = (cnt_q == CNT_W'(1)) ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    load      = 1'b0;
    step      = 1'b0;
    push_dig  = 1'b0;
    emit_sign = 1'b0;
    rd_en     = 1'b0;
    emit_dig  = 1'b0;
    case (state_q)
      ST_IDLE: load = !empty_i;
      ST_DIV: begin
        step     = 1'b1;
        push_dig = div_done;
      end
      ST_SIGN: emit_sign = slot_free;
      ST_READ: rd_en = 1'b1;
      ST_OUT:  emit_dig = slot_free;
      default: ;
    endcase
  end

  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        cnt_q <= '0;
      end else if (push_dig) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (emit_dig) begin
        cnt_q <= cnt_m1;
      end
      if (emit_sign || emit_dig) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q  <= pop_data_i[VALUE_BITS];
      quot_q <= pop_data_i[VALUE_BITS-1:0];
      rem_q  <= '0;
      bit_q  <= AW'(VALUE_BITS - 1);
    end else if (step) begin
      quot_q <= quot_next;
      if (div_done) begin
        rem_q <= '0;
        bit_q <= AW'(VALUE_BITS - 1);
      end else begin
        rem_q <= rem_next;
        bit_q <= bit_q - AW'(1);
      end
    end
    if (emit_sign) begin
      char_q <= CHAR_MINUS;
      last_q <= 1'b0;
    end else if (emit_dig) begin
      char_q <= digit_char(cfg_i, rd_q);
      last_q <= cnt_q == CNT_W'(1);
    end
  end

  // digit stack
  always_ff @(posedge clk_i) begin
    if (push_dig) begin
      stack_q[cnt_q[AW-1:0]] <= DIGIT_W'(rem_next);
    end
    if (rd_en) begin
      rd_q <= stack_q[cnt_m1[AW-1:0]];
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(VALUE_BITS))
    else $error("digit count beyond stack depth");

  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (trial_sub[REM_W] == 1'b0 || !ge || rem_q < radix_r[REM_W-1:0]
      || radix_r[REM_W]))
    else $error("partial remainder not below radix");

  a_out_has_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT || state_q == ST_READ) |-> (cnt_q != '0))
    else $error("reading an empty digit stack");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && char_q == CHAR_MINUS) |-> !last_q)
    else $error("minus sign flagged as last character");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE))
    else $error("queue popped during conversion");
`endif

endmodule
